// ----- design/dmb_pkg.sv -----
// ----------------------------------------------------------------------------
// dmb_pkg: shared constants and types
// Widths, polynomial constants, operation codes and the queue entry format
// used by the single-bin DFT magnitude block.
// ----------------------------------------------------------------------------
package dmb_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SAMPLE_W    = 16;
	localparam int PHASE_W     = 32;
	localparam int BIN_W       = 16;
	localparam int MAG_W       = 44;
	localparam int PROD_W      = BIN_W + PHASE_W;

	// Each product is below 2^30 in magnitude, so the sums fit in ACC_W signed bits.
	localparam int ACC_W       = SAMPLE_W + 16 + ADDR_W;
	localparam int ABS_W       = ACC_W - 1;
	localparam int HALF_W      = 22;
	localparam int HI_W        = ABS_W - HALF_W;
	localparam int SUMSQ_W     = 2 * MAG_W;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd611929;

	localparam logic [16:0] POLY_A = 17'd102944;
	localparam logic [16:0] POLY_B = 17'd42047;
	localparam logic [12:0] POLY_C = 13'd4640;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [BIN_W-1:0]   bin;
		logic [PHASE_W-1:0] inc;
		logic               beyond;
	} query_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

// ----- design/dmb_if.sv -----
// ----------------------------------------------------------------------------
// dmb_if: channel interfaces
// Input item, result and configuration write channels, each with valid and
// ready and its payload.
// ----------------------------------------------------------------------------
interface dmb_in_if;
	import dmb_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       first_sample;
	logic [BIN_W-1:0]           bin_number;
	modport source (output valid, op, sample, first_sample, bin_number, input ready);
	modport sink (input valid, op, sample, first_sample, bin_number, output ready);
endinterface

interface dmb_out_if;
	import dmb_pkg::*;
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] bin_echo;
	logic [MAG_W-1:0] magnitude;
	logic             beyond_nyquist;
	modport source (output valid, bin_echo, magnitude, beyond_nyquist, input ready);
	modport sink (input valid, bin_echo, magnitude, beyond_nyquist, output ready);
endinterface

interface dmb_cfg_if;
	import dmb_pkg::*;
	logic               valid;
	logic               ready;
	logic [PHASE_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- design/dft_magnitude_at_bin.sv -----
// ----------------------------------------------------------------------------
// dft_magnitude_at_bin: single-bin DFT magnitude
// Stores a block of samples and returns the DFT magnitude at a queried bin.
// ----------------------------------------------------------------------------
// Usage: items arrive on the item channel. A store item (op 0) writes one
// sample; first_sample restarts the block at entry zero, and samples past
// 4096 are dropped. A store is held off while a query is queued
// or being computed. A query item (op 1) enters a two-entry queue and
// produces one transaction on the result channel.
// A query streams one sample per cycle through the sine and accumulate
// pipeline, set by the single read port of the sample memory, then squares
// the sums on a shared 22x22 multiplier and takes a bit-serial square root.
// Bins at or above Nyquist skip the work and answer with magnitude zero.
// The phase_step register is written on the cfg channel, always ready; the
// user must write it only while the block is idle, which the block does not
// enforce. Reset restores phase_step and empties the block; the sample memory
// is not cleared and needs no clearing pass. While the receiver stalls, the
// result is held and further queries wait in the queue until it is full.
// ----------------------------------------------------------------------------
module dft_magnitude_at_bin (
	input  logic      clk,
	input  logic      arst_n,
	dmb_in_if.sink    item,
	dmb_out_if.source result,
	dmb_cfg_if.sink   cfg
);
	import dmb_pkg::*;

	logic                push;
	query_t              push_entry;
	query_t              head;
	q_status_t           q_stat;
	logic                pop;
	logic                back_busy;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [SAMPLE_W-1:0] wr_data;
	logic [CNT_W-1:0]    count;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [SAMPLE_W-1:0] rd_data;

	dmb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.back_busy  (back_busy),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.count      (count)
	);

	dmb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	dmb_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dmb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (!q_stat.empty),
		.q_entry (head),
		.pop     (pop),
		.count   (count),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.result  (result),
		.busy    (back_busy)
	);

endmodule

// ----- design/dmb_ram.sv -----
// ----------------------------------------------------------------------------
// dmb_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dmb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- design/dmb_front.sv -----
// ----------------------------------------------------------------------------
// dmb_front: item intake
// Holds the phase step register, writes stored samples and the sample count,
// and turns each query into a queue entry with its phase increment.
// ----------------------------------------------------------------------------
module dmb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	dmb_in_if.sink                      item,
	dmb_cfg_if.sink                     cfg,
	input  logic                        back_busy,
	input  dmb_pkg::q_status_t          q_stat,
	output logic                        push,
	output dmb_pkg::query_t             push_entry,
	output logic                        wr_en,
	output logic [dmb_pkg::ADDR_W-1:0]  wr_addr,
	output logic [dmb_pkg::SAMPLE_W-1:0] wr_data,
	output logic [dmb_pkg::CNT_W-1:0]   count
);
	import dmb_pkg::*;

	logic [PHASE_W-1:0] phase_step_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   eff_count;
	logic [PROD_W-1:0]  prod;
	logic               acc;

	assign cfg.ready = 1'b1;

	// A store must wait until no query still reads the sample store.
	assign item.ready = (item.op == OP_QUERY) ? !q_stat.full : (q_stat.empty && !back_busy);
	assign acc        = item.valid && item.ready;

	assign prod = PROD_W'(item.bin_number) * PROD_W'(phase_step_q);

	assign push              = acc && (item.op == OP_QUERY);
	assign push_entry.bin    = item.bin_number;
	assign push_entry.inc    = prod[PHASE_W-1:0];
	assign push_entry.beyond = |prod[PROD_W-1:PHASE_W-1];

	assign eff_count = item.first_sample ? '0 : count_q;
	assign wr_en     = acc && (item.op == OP_STORE) && (eff_count < CNT_W'(MAX_SAMPLES));
	assign wr_addr   = eff_count[ADDR_W-1:0];
	assign wr_data   = item.sample;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RST;
			count_q      <= '0;
		end else begin
			if (cfg.valid) begin
				phase_step_q <= cfg.data;
			end
			if (wr_en) begin
				count_q <= eff_count + CNT_W'(1);
			end
		end
	end

endmodule

// ----- design/dmb_queue.sv -----
// ----------------------------------------------------------------------------
// dmb_queue: query queue
// Short FIFO that lets the intake take queries while a query is computed.
// ----------------------------------------------------------------------------
module dmb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dmb_pkg::query_t    push_entry,
	input  logic               pop,
	output dmb_pkg::query_t    head,
	output dmb_pkg::q_status_t stat
);
	import dmb_pkg::*;

	query_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == (QPTR_W+1)'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- design/dmb_back.sv -----
// ----------------------------------------------------------------------------
// dmb_back: query engine
// Streams the stored samples through a sine pipeline and two accumulators,
// squares the sums with a shared multiplier and takes the square root one
// bit per cycle; a query beyond Nyquist skips straight to the result.
// ----------------------------------------------------------------------------
module dmb_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  dmb_pkg::query_t              q_entry,
	output logic                         pop,
	input  logic [dmb_pkg::CNT_W-1:0]    count,
	output logic                         rd_en,
	output logic [dmb_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [dmb_pkg::SAMPLE_W-1:0] rd_data,
	dmb_out_if.source                    result,
	output logic                         busy
);
	import dmb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_ROOT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]         state_q;
	logic [BIN_W-1:0]   bin_q;
	logic               beyond_q;
	logic [PHASE_W-1:0] inc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	logic [PHASE_W-1:0] ph_q;
	logic signed [ACC_W-1:0] re_q;
	logic signed [ACC_W-1:0] im_q;
	logic [ABS_W-1:0]   absr_q;
	logic [ABS_W-1:0]   absi_q;
	logic [2:0]         sq_step_q;
	logic [2*HALF_W-1:0] mprod_q;
	logic [1:0]         mkind_q;
	logic               mvld_q;
	logic [SUMSQ_W-1:0] sum_q;
	logic [MAG_W+1:0]   rem_q;
	logic [MAG_W-1:0]   root_q;
	logic [5:0]         rstep_q;

	// Sample pipeline
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [PHASE_W-1:0] ph_s1;
	logic [1:0]         quad_s2, quad_s3, quad_s4, quad_s5;
	logic [16:0]        xu_s2, xd_s2, xu_s3, xd_s3, xu_s4, xd_s4;
	logic [16:0]        x2u_s2, x2d_s2, x2u_s3, x2d_s3;
	logic [16:0]        tu_s3, td_s3;
	logic [16:0]        pu_s4, pd_s4;
	logic [14:0]        su_s5, sd_s5;
	logic signed [SAMPLE_W-1:0] smp_s2, smp_s3, smp_s4, smp_s5;
	logic signed [32:0] pc_s6, ps_s6;

	logic               issue;
	logic               pipe_busy;
	logic [16:0]        xu_c, xd_c;
	logic [33:0]        mxu, mxd;
	logic [29:0]        mcu, mcd;
	logic [33:0]        mtu, mtd;
	logic [33:0]        mpu, mpd;
	logic [17:0]        ru, rd;
	logic signed [16:0] c_sel, s_sel;
	logic signed [32:0] pc_c, ps_c;
	logic signed [ACC_W-1:0] are, aim;
	logic [ABS_W-1:0]   sq_op;
	logic [HALF_W-1:0]  ma, mb;
	logic [1:0]         kind;
	logic [SUMSQ_W-1:0] addend;
	logic [MAG_W+1:0]   r2, trial;

	assign busy    = (state_q != ST_IDLE);
	assign pop     = (state_q == ST_IDLE) && q_valid;
	assign issue   = (state_q == ST_RUN) && (idx_q < cnt_q);
	assign rd_en   = issue;
	assign rd_addr = idx_q[ADDR_W-1:0];
	assign pipe_busy = vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5 | vld_s6;

	assign result.valid          = (state_q == ST_DONE);
	assign result.bin_echo       = bin_q;
	assign result.magnitude      = root_q;
	assign result.beyond_nyquist = beyond_q;

	// Quarter-wave sine polynomial, one multiply per stage, for x and for 1-x.
	assign xu_c = {1'b0, ph_s1[29:14]};
	assign xd_c = 17'd65536 - xu_c;
	assign mxu  = 34'(xu_c) * 34'(xu_c);
	assign mxd  = 34'(xd_c) * 34'(xd_c);
	assign mcu  = 30'(POLY_C) * 30'(x2u_s2);
	assign mcd  = 30'(POLY_C) * 30'(x2d_s2);
	assign mtu  = 34'(tu_s3) * 34'(x2u_s3);
	assign mtd  = 34'(td_s3) * 34'(x2d_s3);
	assign mpu  = 34'(pu_s4) * 34'(xu_s4);
	assign mpd  = 34'(pd_s4) * 34'(xd_s4);
	assign ru   = (mpu[33:16] + 18'd1) >> 1;
	assign rd   = (mpd[33:16] + 18'd1) >> 1;

	always_comb begin
		case (quad_s5)
			2'd0: begin
				s_sel = $signed({2'b00, su_s5});
				c_sel = $signed({2'b00, sd_s5});
			end
			2'd1: begin
				s_sel = $signed({2'b00, sd_s5});
				c_sel = -$signed({2'b00, su_s5});
			end
			2'd2: begin
				s_sel = -$signed({2'b00, su_s5});
				c_sel = -$signed({2'b00, sd_s5});
			end
			default: begin
				s_sel = -$signed({2'b00, sd_s5});
				c_sel = $signed({2'b00, su_s5});
			end
		endcase
	end

	assign pc_c = 33'(smp_s5) * 33'(c_sel);
	assign ps_c = 33'(smp_s5) * 33'(s_sel);

	assign are = re_q[ACC_W-1] ? -re_q : re_q;
	assign aim = im_q[ACC_W-1] ? -im_q : im_q;

	// Squares in 22-bit pieces: high*high, twice high*low, low*low.
	assign sq_op = (sq_step_q < 3'd3) ? absr_q : absi_q;
	always_comb begin
		case (sq_step_q)
			3'd0, 3'd3: kind = 2'd0;
			3'd1, 3'd4: kind = 2'd1;
			default:    kind = 2'd2;
		endcase
	end
	assign ma = (kind == 2'd2) ? sq_op[HALF_W-1:0] : HALF_W'(sq_op[ABS_W-1:HALF_W]);
	assign mb = (kind == 2'd0) ? HALF_W'(sq_op[ABS_W-1:HALF_W]) : sq_op[HALF_W-1:0];

	always_comb begin
		case (mkind_q)
			2'd0:    addend = SUMSQ_W'(mprod_q) << (2 * HALF_W);
			2'd1:    addend = SUMSQ_W'(mprod_q) << (HALF_W + 1);
			default: addend = SUMSQ_W'(mprod_q);
		endcase
	end

	// Restoring square root. The radicand is below 2^88, so the root always
	// fits in the magnitude field and never needs saturating.
	assign r2    = {rem_q[MAG_W-1:0], sum_q[SUMSQ_W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		ph_s1   <= ph_q;
		xu_s2   <= xu_c;
		xd_s2   <= xd_c;
		x2u_s2  <= mxu[32:16];
		x2d_s2  <= mxd[32:16];
		quad_s2 <= ph_s1[31:30];
		smp_s2  <= rd_data;
		tu_s3   <= POLY_B - 17'(mcu[29:16]);
		td_s3   <= POLY_B - 17'(mcd[29:16]);
		xu_s3   <= xu_s2;
		xd_s3   <= xd_s2;
		x2u_s3  <= x2u_s2;
		x2d_s3  <= x2d_s2;
		quad_s3 <= quad_s2;
		smp_s3  <= smp_s2;
		pu_s4   <= POLY_A - mtu[32:16];
		pd_s4   <= POLY_A - mtd[32:16];
		xu_s4   <= xu_s3;
		xd_s4   <= xd_s3;
		quad_s4 <= quad_s3;
		smp_s4  <= smp_s3;
		su_s5   <= (ru > 18'd32767) ? 15'd32767 : ru[14:0];
		sd_s5   <= (rd > 18'd32767) ? 15'd32767 : rd[14:0];
		quad_s5 <= quad_s4;
		smp_s5  <= smp_s4;
		pc_s6   <= pc_c;
		ps_s6   <= ps_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			mvld_q  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			mvld_q <= (state_q == ST_SQR) && (sq_step_q < 3'd6);
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= q_entry.beyond ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (!issue && !pipe_busy) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (sq_step_q == 3'd6) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rstep_q == 6'(MAG_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (result.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				bin_q    <= q_entry.bin;
				beyond_q <= q_entry.beyond;
				inc_q    <= q_entry.inc;
				cnt_q    <= count;
				idx_q    <= '0;
				ph_q     <= '0;
				re_q     <= '0;
				im_q     <= '0;
				root_q   <= '0;
			end
			ST_RUN: begin
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
					ph_q  <= ph_q + inc_q;
				end
				if (vld_s6) begin
					re_q <= re_q + ACC_W'(pc_s6);
					im_q <= im_q - ACC_W'(ps_s6);
				end
				absr_q    <= are[ABS_W-1:0];
				absi_q    <= aim[ABS_W-1:0];
				sq_step_q <= '0;
				sum_q     <= '0;
			end
			ST_SQR: begin
				mprod_q <= (2*HALF_W)'(ma) * (2*HALF_W)'(mb);
				mkind_q <= kind;
				if (sq_step_q != 3'd6) begin
					sq_step_q <= sq_step_q + 3'd1;
				end
				if (mvld_q) begin
					sum_q <= sum_q + addend;
				end
				rem_q   <= '0;
				root_q  <= '0;
				rstep_q <= '0;
			end
			ST_ROOT: begin
				if (r2 >= trial) begin
					rem_q  <= r2 - trial;
					root_q <= {root_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q  <= r2;
					root_q <= {root_q[MAG_W-2:0], 1'b0};
				end
				sum_q   <= sum_q << 2;
				rstep_q <= rstep_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/dmb_checker.sv -----
// ----------------------------------------------------------------------------
// dmb_checker: port-level checks
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
module dmb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_op,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [dmb_pkg::BIN_W-1:0]   out_bin,
	input logic [dmb_pkg::MAG_W-1:0]   out_mag,
	input logic                        out_beyond
);
	import dmb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bin) && $stable(out_mag)
			&& $stable(out_beyond))
		else $error("result changed while stalled");

	a_nyq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beyond |-> out_mag == '0)
		else $error("beyond Nyquist with nonzero magnitude");

	// The asynchronous reset clears the engine, so no result shows at the next edge.
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_op == OP_STORE) |-> !out_valid)
		else $error("store accepted while a query is still pending");

endmodule

bind dft_magnitude_at_bin dmb_checker u_dmb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.in_op      (item.op),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_bin    (result.bin_echo),
	.out_mag    (result.magnitude),
	.out_beyond (result.beyond_nyquist)
);
